/* src/dpcs_pkg.sv */
// ----------------------------------------------------------------------------
// dpcs_pkg
// Shared constants, codes and transaction types of the path chain store.
// ----------------------------------------------------------------------------
package dpcs_pkg;

    localparam int STORE_BYTES    = 65536;
    localparam int MAX_COLOURS    = 64;
    localparam int MAX_BASES      = 1024;
    localparam int LEN_FIELD_BITS = 15;
    localparam int PACK_BYTES     = (MAX_BASES + 3) / 4;
    localparam int LINK_BYTES     = 8;
    localparam int WORD_BYTES     = 2;

    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int PACK_AW = $clog2(PACK_BYTES);
    localparam int CNT_W   = $clog2(MAX_BASES + 1);

    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_MERGED   = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    localparam logic [1:0] CFG_NUM_COLOURS = 2'd0;
    localparam logic [1:0] CFG_STORE_SIZE  = 2'd1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_rec_req;

    typedef struct packed {
        logic       push;
        logic       last;
        logic [1:0] base;
    } t_pack_ctl;

endpackage

/* src/dpcs_rec_mem.sv */
// ----------------------------------------------------------------------------
// dpcs_rec_mem
// Record byte store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dpcs_rec_mem
    import dpcs_pkg::*;
(
    input  logic     i_clk,
    input  t_rec_req i_req,
    output logic [7:0] o_rdata_a,
    output logic [7:0] o_rdata_b
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata_a;
    logic [7:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* src/dpcs_pack.sv */
// ----------------------------------------------------------------------------
// dpcs_pack
// Packs incoming bases four to a byte into the path buffer.
// ----------------------------------------------------------------------------
module dpcs_pack
    import dpcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pack_ctl          i_ctl,
    input  logic [PACK_AW-1:0] i_raddr,
    output logic [7:0]         o_rdata,
    output logic [CNT_W-1:0]   o_count
);

    logic [7:0]       r_mem [PACK_BYTES];
    logic [7:0]       r_rdata;
    logic [7:0]       r_byte;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       n_byte;
    logic             room;

    assign room = (r_count < CNT_W'(MAX_BASES));

    always_comb begin
        if (r_count[1:0] == 2'd0) begin
            n_byte = {6'd0, i_ctl.base};
        end else begin
            n_byte = r_byte | (8'({6'd0, i_ctl.base}) << {r_count[1:0], 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && room) begin
            r_mem[r_count[PACK_AW+1:2]] <= n_byte;
            r_byte <= n_byte;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.push) begin
            if (i_ctl.last) begin
                r_count <= '0;
            end else if (room) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

/* src/dedup_path_chain_store.sv */
// ----------------------------------------------------------------------------
// dedup_path_chain_store
// Append-only store of packed path records, chained, with duplicates merged.
// ----------------------------------------------------------------------------
// Usage:
//   A path is sent one base per transaction: raise start while busy is low.
//   A base that is not the last leaves busy low and gives no result.
//   The last base gives exactly one result, shown for one cycle with
//   o_result_valid: status, record offset and the two running counts.
//   Out of memory is reported in the cycle after the last base; otherwise the
//   record (link, colour bytes, length word, packed bases) is written byte by
//   byte, one a cycle for link, colour and word bytes and each base byte after
//   a read of the path buffer; then, unless the chain is empty, it is walked
//   from chain_head: each visited record is compared byte by byte up to the
//   first mismatch, on which its eight link bytes are fetched, and a merge
//   that sets a colour bit reads and rewrites that colour byte. busy stays
//   high for the whole of that work; the receiver cannot stall. Reset clears
//   counters and the free pointer; the memories need no clear. Configuration
//   is to be written via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the
//   user must see to it, the block does not enforce it.
// ----------------------------------------------------------------------------
module dedup_path_chain_store
    import dpcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_chain_head,
    input  logic        i_chain_empty,
    input  logic [10:0] i_path_len,
    input  logic        i_orientation,
    input  logic [5:0]  i_colour,
    input  logic [1:0]  i_base,
    input  logic        i_last_base,
    output logic        o_result_valid,
    output logic [15:0] o_record_offset,
    output logic [1:0]  o_status,
    output logic [15:0] o_paths_stored,
    output logic [15:0] o_heads_with_paths
);

    typedef enum logic [3:0] {
        S_IDLE, S_LINK, S_COL, S_WORD, S_BRD, S_BWR,
        S_CRD, S_CCK, S_LRD, S_LCK, S_MRD, S_MWR
    } t_state;

    t_state      r_state;
    logic [6:0]  r_num_colours;
    logic [16:0] r_store_size;
    logic [16:0] r_next_free;
    logic [15:0] r_path_count;
    logic [15:0] r_head_count;
    logic [15:0] r_start;
    logic [15:0] r_cur;
    logic [15:0] r_head;
    logic        r_empty;
    logic [5:0]  r_colour;
    logic        r_col_ok;
    logic [CNT_W-1:0] r_rcv;
    logic [1:0]  r_len2;
    logic [8:0]  r_nbytes;
    logic [3:0]  r_cbb;
    logic [4:0]  r_qoff;
    logic [9:0]  r_total;
    logic [15:0] r_word;
    logic [8:0]  r_idx;
    logic [15:0] r_link_lo;
    logic        r_ones;
    logic        r_hinz;
    logic        r_valid;
    logic [15:0] r_offset;
    logic [1:0]  r_status;
    logic [15:0] r_paths_out;
    logic [15:0] r_heads_out;

    t_rec_req    mem_req;
    t_pack_ctl   pk_ctl;
    logic [7:0]  rdata_a;
    logic [7:0]  rdata_b;
    logic [7:0]  pk_rdata;
    logic [CNT_W-1:0] pk_count;

    logic        accept;
    logic [10:0] len_c;
    logic [11:0] len_p3;
    logic [8:0]  nbytes_c;
    logic [6:0]  cols_c;
    logic [3:0]  cbb_c;
    logic [9:0]  total_c;
    logic [16:0] limit_c;
    logic        oom_c;
    logic [7:0]  base_byte;
    logic [7:0]  mask;
    logic [7:0]  col_bit;
    logic [15:0] col_addr;
    logic        ones_f;
    logic        hinz_f;
    logic [15:0] link_f;

    assign accept = i_rst_n && start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign pk_ctl.push = accept;
    assign pk_ctl.last = i_last_base;
    assign pk_ctl.base = i_base;

    dpcs_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pk_ctl),
        .i_raddr (r_idx[PACK_AW-1:0]),
        .o_rdata (pk_rdata),
        .o_count (pk_count)
    );

    dpcs_rec_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        len_c    = (i_path_len > 11'(MAX_BASES)) ? 11'(MAX_BASES) : i_path_len;
        len_p3   = {1'b0, len_c} + 12'd3;
        nbytes_c = len_p3[10:2];
        if (r_num_colours == 7'd0) begin
            cols_c = 7'd1;
        end else if (r_num_colours > 7'(MAX_COLOURS)) begin
            cols_c = 7'(MAX_COLOURS);
        end else begin
            cols_c = r_num_colours;
        end
        cbb_c   = 4'((cols_c + 7'd7) >> 3);
        total_c = 10'(LINK_BYTES + WORD_BYTES) + 10'(cbb_c) + 10'(nbytes_c);
        limit_c = (r_store_size < 17'(STORE_BYTES)) ? r_store_size : 17'(STORE_BYTES);
        oom_c   = ({1'b0, r_next_free} + 18'(total_c)) >= {1'b0, limit_c};
    end

    always_comb begin
        case (r_len2)
            2'd1:    mask = 8'h03;
            2'd2:    mask = 8'h0F;
            2'd3:    mask = 8'h3F;
            default: mask = 8'hFF;
        endcase
        base_byte = ({1'b0, r_idx[7:0], 2'b00} < r_rcv) ? pk_rdata : 8'h00;
        if (r_idx == r_nbytes - 9'd1) begin
            base_byte = base_byte & mask;
        end
        col_bit  = 8'd1 << r_colour[2:0];
        col_addr = r_cur + 16'(LINK_BYTES) + 16'(r_colour[5:3]);
        ones_f   = r_ones && (rdata_a == 8'hFF);
        hinz_f   = r_hinz || (rdata_a != 8'h00);
        link_f   = r_link_lo;
    end

    always_comb begin
        mem_req.we      = 1'b0;
        mem_req.waddr   = r_start;
        mem_req.wdata   = 8'h00;
        mem_req.raddr_a = r_cur + 16'(r_qoff) + 16'(r_idx);
        mem_req.raddr_b = r_start + 16'(r_qoff) + 16'(r_idx);
        unique case (r_state)
            S_LINK: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_start + 16'(r_idx[2:0]);
                if (r_empty) begin
                    mem_req.wdata = 8'hFF;
                end else if (r_idx == 9'd0) begin
                    mem_req.wdata = r_head[7:0];
                end else if (r_idx == 9'd1) begin
                    mem_req.wdata = r_head[15:8];
                end
            end
            S_COL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_start + 16'(LINK_BYTES) + 16'(r_idx);
                if (r_col_ok && (r_idx[2:0] == r_colour[5:3])) begin
                    mem_req.wdata = col_bit;
                end
            end
            S_WORD: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_start + 16'(r_qoff) + 16'(r_idx);
                mem_req.wdata = r_idx[0] ? r_word[15:8] : r_word[7:0];
            end
            S_BWR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_start + 16'(r_qoff) + 16'(WORD_BYTES) + 16'(r_idx);
                mem_req.wdata = base_byte;
            end
            S_LRD: begin
                mem_req.raddr_a = r_cur + 16'(r_idx);
            end
            S_MRD: begin
                mem_req.raddr_a = col_addr;
            end
            S_MWR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = col_addr;
                mem_req.wdata = rdata_a | col_bit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_colours <= 7'd1;
            r_store_size  <= 17'd65536;
            r_next_free   <= '0;
            r_path_count  <= '0;
            r_head_count  <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUM_COLOURS: r_num_colours <= i_cfg_data[6:0];
                    CFG_STORE_SIZE:  r_store_size  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_last_base) begin
                        r_rcv    <= (pk_count < CNT_W'(MAX_BASES)) ?
                                    pk_count + CNT_W'(1) : pk_count;
                        r_len2   <= len_c[1:0];
                        r_nbytes <= nbytes_c;
                        r_cbb    <= cbb_c;
                        r_qoff   <= 5'(LINK_BYTES) + 5'(cbb_c);
                        r_total  <= total_c;
                        r_word   <= 16'(len_c) | (16'(i_orientation) << LEN_FIELD_BITS);
                        r_head   <= i_chain_head;
                        r_empty  <= i_chain_empty;
                        r_colour <= i_colour;
                        r_col_ok <= (7'(i_colour) < cols_c);
                        r_start  <= r_next_free[15:0];
                        r_cur    <= i_chain_head;
                        r_idx    <= '0;
                        if (oom_c) begin
                            r_valid     <= 1'b1;
                            r_offset    <= '0;
                            r_status    <= ST_NO_SPACE;
                            r_paths_out <= r_path_count;
                            r_heads_out <= r_head_count;
                        end else begin
                            r_state <= S_LINK;
                        end
                    end
                end
                S_LINK: begin
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'(LINK_BYTES - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'(r_cbb) - 9'd1) begin
                        r_idx   <= '0;
                        r_state <= S_WORD;
                    end
                end
                S_WORD: begin
                    r_idx <= r_idx + 9'd1;
                    if (r_idx == 9'd1) begin
                        r_idx <= '0;
                        if (r_nbytes != 9'd0) begin
                            r_state <= S_BRD;
                        end else if (r_empty) begin
                            r_state     <= S_IDLE;
                            r_next_free <= r_next_free + 17'(r_total);
                            r_path_count <= r_path_count + 16'd1;
                            r_head_count <= r_head_count + 16'd1;
                            r_valid     <= 1'b1;
                            r_offset    <= r_start;
                            r_status    <= ST_APPENDED;
                            r_paths_out <= r_path_count + 16'd1;
                            r_heads_out <= r_head_count + 16'd1;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end
                end
                S_BRD: begin
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_idx   <= r_idx + 9'd1;
                    r_state <= S_BRD;
                    if (r_idx == r_nbytes - 9'd1) begin
                        r_idx <= '0;
                        if (r_empty) begin
                            r_state     <= S_IDLE;
                            r_next_free <= r_next_free + 17'(r_total);
                            r_path_count <= r_path_count + 16'd1;
                            r_head_count <= r_head_count + 16'd1;
                            r_valid     <= 1'b1;
                            r_offset    <= r_start;
                            r_status    <= ST_APPENDED;
                            r_paths_out <= r_path_count + 16'd1;
                            r_heads_out <= r_head_count + 16'd1;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end
                end
                S_CRD: begin
                    r_state <= S_CCK;
                end
                S_CCK: begin
                    if (rdata_a != rdata_b) begin
                        r_idx   <= '0;
                        r_ones  <= 1'b1;
                        r_hinz  <= 1'b0;
                        r_state <= S_LRD;
                    end else if (r_idx == r_nbytes + 9'd1) begin
                        r_idx <= '0;
                        if (r_col_ok) begin
                            r_state <= S_MRD;
                        end else begin
                            r_state     <= S_IDLE;
                            r_valid     <= 1'b1;
                            r_offset    <= '0;
                            r_status    <= ST_MERGED;
                            r_paths_out <= r_path_count;
                            r_heads_out <= r_head_count;
                        end
                    end else begin
                        r_idx   <= r_idx + 9'd1;
                        r_state <= S_CRD;
                    end
                end
                S_LRD: begin
                    r_state <= S_LCK;
                end
                S_LCK: begin
                    r_ones <= ones_f;
                    if (r_idx == 9'd0) begin
                        r_link_lo[7:0] <= rdata_a;
                    end else if (r_idx == 9'd1) begin
                        r_link_lo[15:8] <= rdata_a;
                    end else begin
                        r_hinz <= hinz_f;
                    end
                    if (r_idx == 9'(LINK_BYTES - 1)) begin
                        r_idx <= '0;
                        if (ones_f || hinz_f || (link_f >= r_cur)) begin
                            r_state     <= S_IDLE;
                            r_next_free <= r_next_free + 17'(r_total);
                            r_path_count <= r_path_count + 16'd1;
                            r_valid     <= 1'b1;
                            r_offset    <= r_start;
                            r_status    <= ST_APPENDED;
                            r_paths_out <= r_path_count + 16'd1;
                            r_heads_out <= r_head_count;
                        end else begin
                            r_cur   <= link_f;
                            r_state <= S_CRD;
                        end
                    end else begin
                        r_idx   <= r_idx + 9'd1;
                        r_state <= S_LRD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    r_state     <= S_IDLE;
                    r_valid     <= 1'b1;
                    r_offset    <= '0;
                    r_status    <= ST_MERGED;
                    r_paths_out <= r_path_count;
                    r_heads_out <= r_head_count;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid     = r_valid;
    assign o_record_offset    = r_offset;
    assign o_status           = r_status;
    assign o_paths_stored     = r_paths_out;
    assign o_heads_with_paths = r_heads_out;

endmodule

/* src/dpcs_checker.sv */
// ----------------------------------------------------------------------------
// dpcs_checker
// Port-level checks of the path chain store, bound to the top level.
// ----------------------------------------------------------------------------
module dpcs_checker
    import dpcs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last_base,
    input logic        o_result_valid,
    input logic [15:0] o_record_offset,
    input logic [1:0]  o_status
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_valid)
        else $error("activity right after reset");

    a_base_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_base) |=> !o_result_valid)
        else $error("result after a non-final base");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_APPENDED) |-> o_record_offset == 16'd0)
        else $error("non-zero offset without append");

endmodule

bind dedup_path_chain_store dpcs_checker u_dpcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_last_base     (i_last_base),
    .o_result_valid  (o_result_valid),
    .o_record_offset (o_record_offset),
    .o_status        (o_status)
);

/* tb/dedup_path_chain_store_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_path_chain_store_test
// Self-checking bench for the path chain store. Paths are sent base by base,
// a byte-level model of the store predicts each record outcome, and a monitor
// checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module dedup_path_chain_store_test;
    import dpcs_pkg::*;

    typedef struct packed {
        logic [15:0] offset;
        logic [1:0]  status;
        logic [15:0] paths;
        logic [15:0] heads;
    } t_outcome;

    typedef struct {
        int         len;
        bit         orient;
        int         nb;
        bit [1:0]   bases [64];
    } t_path;

    localparam int NUM_CHAINS  = 8;
    localparam int CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_chain_head = '0;
    logic        i_chain_empty = 1'b0;
    logic [10:0] i_path_len = '0;
    logic        i_orientation = 1'b0;
    logic [5:0]  i_colour = '0;
    logic [1:0]  i_base = '0;
    logic        i_last_base = 1'b0;
    logic        o_result_valid;
    logic [15:0] o_record_offset;
    logic [1:0]  o_status;
    logic [15:0] o_paths_stored;
    logic [15:0] o_heads_with_paths;

    dedup_path_chain_store dut (.*);

    always #1 i_clk = ~i_clk;

    // store model
    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] packed_bases [PACK_BYTES];
    int         free_ptr, stored_count, head_count, bases_in;
    int         colours_reg = 1, size_reg = 65536;

    t_outcome   outcome_q [$];
    int         mismatches = 0;
    longint     cycles = 0;
    int         idle_pct = 0;

    int         chain_top [NUM_CHAINS];
    bit         chain_live [NUM_CHAINS];
    int         chain_depth [NUM_CHAINS];
    t_path      path_pool [$];
    bit [1:0]   path_bases [0:1099];

    function automatic int colour_bytes(int ncol);
        int c;
        c = ncol < 1 ? 1 : (ncol > MAX_COLOURS ? MAX_COLOURS : ncol);
        return (c + 7) / 8;
    endfunction

    function automatic bit predict_store(input int head, input bit empty, input int len_in,
                                         input bit orient, input int colour, input bit [1:0] b,
                                         input bit last, output t_outcome res);
        int        rcv, len, nbytes, cols, cbb, total, limit, qlen, cur, i, begin_at;
        logic [7:0] query [WORD_BYTES + PACK_BYTES];
        logic [7:0] v;
        logic [15:0] word;
        longint unsigned link;
        bit        same;
        if (bases_in < MAX_BASES) begin
            if ((bases_in & 3) == 0) packed_bases[bases_in >> 2] = {6'd0, b};
            else packed_bases[bases_in >> 2] |= 8'(b) << ((bases_in & 3) * 2);
            bases_in++;
        end
        if (!last) return 0;
        rcv = bases_in;
        bases_in = 0;
        len = len_in > MAX_BASES ? MAX_BASES : len_in;
        nbytes = (len + 3) / 4;
        cols = colours_reg < 1 ? 1 : (colours_reg > MAX_COLOURS ? MAX_COLOURS : colours_reg);
        cbb = (cols + 7) / 8;
        total = LINK_BYTES + cbb + WORD_BYTES + nbytes;
        limit = size_reg < STORE_BYTES ? size_reg : STORE_BYTES;
        if (free_ptr + total >= limit) begin
            res = '{16'd0, ST_NO_SPACE, 16'(stored_count), 16'(head_count)};
            return 1;
        end
        word = 16'(len % (1 << LEN_FIELD_BITS)) | (16'(orient) << LEN_FIELD_BITS);
        query[0] = word[7:0];
        query[1] = word[15:8];
        for (i = 0; i < nbytes; i++) begin
            v = (4 * i < rcv) ? packed_bases[i] : 8'd0;
            if (i + 1 == nbytes && (len & 3) != 0) v &= (8'd1 << (2 * (len & 3))) - 8'd1;
            query[WORD_BYTES + i] = v;
        end
        qlen = WORD_BYTES + nbytes;
        begin_at = free_ptr;
        for (i = 0; i < LINK_BYTES; i++)
            store_mem[16'(begin_at + i)] = empty ? 8'hFF : (i < 2 ? 8'(head >> (8 * i)) : 8'd0);
        for (i = 0; i < cbb; i++) store_mem[16'(begin_at + LINK_BYTES + i)] = 8'd0;
        if (colour < cols)
            store_mem[16'(begin_at + LINK_BYTES + colour / 8)] |= 8'd1 << (colour % 8);
        for (i = 0; i < qlen; i++) store_mem[16'(begin_at + LINK_BYTES + cbb + i)] = query[i];
        if (!empty) begin
            cur = head;
            forever begin
                same = 1;
                for (i = 0; i < qlen && same; i++)
                    if (store_mem[16'(cur + LINK_BYTES + cbb + i)] != query[i]) same = 0;
                if (same) begin
                    if (colour < cols)
                        store_mem[16'(cur + LINK_BYTES + colour / 8)] |= 8'd1 << (colour % 8);
                    res = '{16'd0, ST_MERGED, 16'(stored_count), 16'(head_count)};
                    return 1;
                end
                link = 0;
                for (i = 0; i < LINK_BYTES; i++)
                    link |= longint'(store_mem[16'(cur + i)]) << (8 * i);
                if (link == 64'hFFFF_FFFF_FFFF_FFFF || link >= longint'(cur)) break;
                cur = int'(link);
            end
        end
        free_ptr = begin_at + total;
        stored_count = (stored_count + 1) & 16'hFFFF;
        if (empty) head_count = (head_count + 1) & 16'hFFFF;
        res = '{16'(begin_at), ST_APPENDED, 16'(stored_count), 16'(head_count)};
        return 1;
    endfunction

    task automatic send_base(input int head, input bit empty, input int len, input bit orient,
                             input int colour, input bit [1:0] b, input bit last);
        t_outcome res;
        int       gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (predict_store(head, empty, len, orient, colour, b, last, res))
            outcome_q.push_back(res);
        start         <= 1'b1;
        i_chain_head  <= 16'(head);
        i_chain_empty <= empty;
        i_path_len    <= 11'(len);
        i_orientation <= orient;
        i_colour      <= 6'(colour);
        i_base        <= b;
        i_last_base   <= last;
        do @(posedge i_clk); while (busy);
    endtask

    // send path_bases[0..nb-1]; returns outcome of the final base
    task automatic send_path(input int head, input bit empty, input int len, input bit orient,
                             input int colour, input int nb, output t_outcome res);
        for (int i = 0; i < nb; i++)
            send_base(head, empty, len, orient, colour, path_bases[i], i == nb - 1);
        res = outcome_q[$];
    endtask

    task automatic drain();
        start <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (outcome_q.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        int old_cbb;
        drain();
        old_cbb = colour_bytes(colours_reg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 17'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NUM_COLOURS) colours_reg = value & 8'h7F;
        else if (idx == CFG_STORE_SIZE) size_reg = value & 17'h1FFFF;
        // drop chains whose layout no longer matches
        if (colour_bytes(colours_reg) != old_cbb)
            for (int k = 0; k < NUM_CHAINS; k++) chain_live[k] = 0;
    endtask

    task automatic random_path(input int k, input bit use_pool, output int n_sent);
        t_outcome res;
        t_path    p;
        bit       empty;
        int       len, nb, head;
        empty = !chain_live[k] || chain_depth[k] > 20 || $urandom_range(15) == 0;
        if (use_pool && path_pool.size() != 0) begin
            p = path_pool[$urandom_range(path_pool.size() - 1)];
        end else begin
            p.nb = $urandom_range(1, ($urandom_range(9) == 0) ? 60 : 12);
            p.len = p.nb;
            p.orient = $urandom_range(1);
            for (int i = 0; i < p.nb; i++) p.bases[i] = $urandom_range(3);
            if (path_pool.size() < 16) path_pool.push_back(p);
        end
        nb = p.nb;
        len = p.len;
        if ($urandom_range(9) == 0) len = $urandom_range(2047);
        for (int i = 0; i < nb; i++) path_bases[i] = p.bases[i];
        head = empty ? $urandom_range(65535) : chain_top[k];
        send_path(head, empty, len, p.orient, $urandom_range(63), nb, res);
        if (res.status == ST_APPENDED) begin
            chain_depth[k] = empty ? 1 : chain_depth[k] + 1;
            chain_top[k] = res.offset;
            chain_live[k] = 1;
        end
        n_sent = nb;
    endtask

    task automatic random_items(input int n);
        int sent;
        int nb;
        sent = 0;
        while (sent < n) begin
            random_path($urandom_range(NUM_CHAINS - 1), $urandom_range(99) < 60, nb);
            sent += nb;
            if ($urandom_range(49) == 0) drain();
        end
    endtask

    task automatic test_directed();
        t_outcome res;
        idle_pct = 0;
        // forward then reverse orientation of the same bases on one chain
        for (int i = 0; i < 5; i++) path_bases[i] = 2'(i);
        send_path(16'hFFFF, 1, 5, 0, 0, 5, res);
        chain_top[0] = res.offset; chain_live[0] = 1; chain_depth[0] = 1;
        send_path(chain_top[0], 0, 5, 0, 0, 5, res);
        send_path(chain_top[0], 0, 5, 1, 0, 5, res);
        chain_top[0] = res.offset; chain_depth[0] = 2;
        send_path(chain_top[0], 0, 5, 0, 63, 5, res);
        // zero length, short count, oversize length
        path_bases[0] = 2'd3;
        send_path(16'h0000, 1, 0, 1, 0, 1, res);
        for (int i = 0; i < 3; i++) path_bases[i] = 2'd3;
        send_path(chain_top[0], 0, 9, 0, 0, 3, res);
        for (int i = 0; i < 1030; i++) path_bases[i] = $urandom_range(3);
        send_path(16'hFFFF, 1, 2047, 1, 0, 1030, res);
    endtask

    task automatic test_colours();
        write_reg(CFG_NUM_COLOURS, 64);
        random_items(30);
        write_reg(CFG_NUM_COLOURS, 0);
        random_items(20);
        write_reg(CFG_NUM_COLOURS, 127);
        random_items(20);
        write_reg(CFG_NUM_COLOURS, $urandom_range(2, 63));
        random_items(30);
    endtask

    task automatic test_store_limit();
        write_reg(CFG_STORE_SIZE, 16);
        random_items(20);
        write_reg(CFG_STORE_SIZE, free_ptr + 150);
        random_items(60);
        write_reg(CFG_STORE_SIZE, 17'h1FFFF);
        random_items(20);
        write_reg(CFG_STORE_SIZE, 65536);
    endtask

    task automatic test_idling();
        int pct [4] = '{0, 77, 0, 35};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct[ph];
            write_reg(CFG_NUM_COLOURS, $urandom_range(1, 64));
            random_items(50);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_result_valid) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status %0d", o_status);
            end else begin
                want = outcome_q.pop_front();
                if (o_record_offset !== want.offset || o_status !== want.status ||
                    o_paths_stored !== want.paths || o_heads_with_paths !== want.heads) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp off %0d st %0d paths %0d heads %0d, got %0d %0d %0d %0d",
                                 want.offset, want.status, want.paths, want.heads,
                                 o_record_offset, o_status, o_paths_stored, o_heads_with_paths);
                end
            end
        end
    end

    initial begin
        free_ptr = 0; stored_count = 0; head_count = 0; bases_in = 0;
        for (int k = 0; k < NUM_CHAINS; k++) begin
            chain_live[k] = 0; chain_top[k] = 0; chain_depth[k] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_colours();
        test_store_limit();
        test_idling();
        drain();
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/dpcs_pkg.sv
src/dpcs_rec_mem.sv
src/dpcs_pack.sv
src/dedup_path_chain_store.sv
src/dpcs_checker.sv
tb/dedup_path_chain_store_test.sv
